FILE: rtl/bce_pkg.sv
`default_nettype none

package bce_pkg;

  localparam int MaxPointsDef = 16;
  localparam int CoordWidthDef = 16;

  localparam int CfgW = 5;
  localparam int IdxInW = 4;
  localparam int TW = 17;

  localparam logic [CfgW-1:0] NumPointsReset = 5'd11;
  localparam logic [TW-1:0] TOne = 17'h10000;

  typedef enum logic {
    OpLoad = 1'b0,
    OpEval = 1'b1
  } op_e;

  typedef struct packed {
    logic copy;
    logic step;
    logic shift2;
    logic [TW-1:0] t;
  } lane_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/bce_lane.sv
`default_nettype none

module bce_lane #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            wr_en_i,
  input  wire logic [bce_pkg::IdxInW-1:0]      wr_idx_i,
  input  wire logic signed [COORD_WIDTH-1:0]   wr_data_i,
  input  wire bce_pkg::lane_ctl_t              ctl_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0]   wr_pos_i,
  output logic signed [COORD_WIDTH-1:0]        front_o
);
  import bce_pkg::*;

  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int CW = COORD_WIDTH;
  localparam int QW = CW + 3;
  localparam int PW = CW + 19;
  localparam int RoundBias = 32768;
  localparam logic signed [QW-1:0] HiVal = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [QW-1:0] LoVal = {4'b1111, {(CW-1){1'b0}}};

  logic signed [CW-1:0] pts_q [MAX_POINTS];
  logic signed [CW-1:0] work_q [MAX_POINTS];
  logic signed [CW-1:0] work_d [MAX_POINTS];
  logic signed [CW-1:0] sh1 [MAX_POINTS];
  logic signed [CW-1:0] sh2 [MAX_POINTS];

  logic signed [CW:0]   diff;
  logic signed [TW:0]   t_s;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [QW-1:0] q;
  logic signed [QW-1:0] sum;
  logic signed [CW-1:0] res;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (32'(wr_idx_i) < MAX_POINTS)) begin
      pts_q[IdxW'(wr_idx_i)] <= wr_data_i;
    end
  end

  always_comb begin
    diff = {work_q[0][CW-1], work_q[0]} - {work_q[1][CW-1], work_q[1]};
    t_s  = {1'b0, ctl_i.t};
    prod = PW'(diff) * PW'(t_s);
    rnd  = prod + PW'(RoundBias);
    q    = rnd[16 +: QW];
    sum  = QW'(work_q[1]) + q;
    if (sum > HiVal) begin
      res = HiVal[CW-1:0];
    end else if (sum < LoVal) begin
      res = LoVal[CW-1:0];
    end else begin
      res = sum[CW-1:0];
    end
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_tap
    if (k + 1 < MAX_POINTS) begin : g_s1
      assign sh1[k] = work_q[k+1];
    end else begin : g_s1e
      assign sh1[k] = work_q[k];
    end
    if (k + 2 < MAX_POINTS) begin : g_s2
      assign sh2[k] = work_q[k+2];
    end else begin : g_s2e
      assign sh2[k] = work_q[k];
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      work_d[k] = work_q[k];
      if (ctl_i.copy) begin
        work_d[k] = pts_q[k];
      end else if (ctl_i.step) begin
        if (IdxW'(k) == wr_pos_i) begin
          work_d[k] = res;
        end else if (ctl_i.shift2) begin
          work_d[k] = sh2[k];
        end else begin
          work_d[k] = sh1[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign front_o = work_q[0];

endmodule

`default_nettype wire

FILE: rtl/bce_seq.sv
`default_nettype none

module bce_seq #(
  parameter int MAX_POINTS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [bce_pkg::TW-1:0]         t_param_i,
  input  wire logic [bce_pkg::CfgW-1:0]       num_points_i,
  input  wire logic                           out_free_i,
  output logic                                busy_o,
  output logic                                emit_o,
  output bce_pkg::lane_ctl_t                  ctl_o,
  output logic [$clog2(MAX_POINTS)-1:0]       wr_pos_o
);
  import bce_pkg::*;

  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int NW = (CntW > CfgW) ? CntW : CfgW;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StFin  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] len_q, len_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [TW-1:0]   t_q;
  logic [NW-1:0]   n_w;
  logic [CntW-1:0] n_start;
  logic [CntW-1:0] wp_full;
  logic            last;
  logic            step;

  always_comb begin
    n_w = NW'(num_points_i);
    if (n_w < NW'(2)) begin
      n_start = CntW'(2);
    end else if (n_w > NW'(MAX_POINTS)) begin
      n_start = CntW'(MAX_POINTS);
    end else begin
      n_start = n_w[CntW-1:0];
    end
  end

  assign last = (CntW'(pos_q) + CntW'(2)) == len_q;

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    pos_d   = pos_q;
    step    = 1'b0;
    emit_o  = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StRun;
          len_d   = n_start;
          pos_d   = '0;
        end
      end
      StRun: begin
        step = 1'b1;
        if (last) begin
          len_d = len_q - CntW'(1);
          pos_d = '0;
          if (len_q == CntW'(2)) begin
            state_d = StFin;
          end
        end else begin
          pos_d = pos_q + IdxW'(1);
        end
      end
      StFin: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      len_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == StIdle)) begin
      t_q <= (t_param_i > TOne) ? TOne : t_param_i;
    end
  end

  assign wp_full = last ? (len_q - CntW'(2)) : (len_q - CntW'(1));
  assign wr_pos_o = wp_full[IdxW-1:0];
  assign busy_o = state_q != StIdle;

  always_comb begin
    ctl_o.copy   = start_i && (state_q == StIdle);
    ctl_o.step   = step;
    ctl_o.shift2 = last;
    ctl_o.t      = t_q;
  end

  a_step_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.step |-> (len_q >= CntW'(2)))
    else $error("reduction step with fewer than two points");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> ((CntW'(pos_q) + CntW'(2)) <= len_q))
    else $error("step position beyond current round");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> out_free_i)
    else $error("result emitted into a full output register");

  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == StRun))
    else $error("evaluation did not start");

endmodule

`default_nettype wire

FILE: rtl/bezier_curve_evaluator_top.sv
`default_nettype none

// De Casteljau Bezier evaluator with one lane per coordinate (x, y, z), each lane
// holding its own control point store and a single multiply-based interpolation
// unit. A load word (op 0) writes one control point into each lane's store. An
// evaluate word (op 1) runs n*(n-1)/2 interpolations in each lane, one
// interpolation per cycle, where n is the clamped point count. The input is
// stalled while an evaluation runs and while its result waits for the output
// register to free up.
// Evaluating with a control point slot that was never loaded gives undefined
// coordinates.
module bezier_curve_evaluator_top #(
  parameter int MAX_POINTS = bce_pkg::MaxPointsDef,
  parameter int COORD_WIDTH = bce_pkg::CoordWidthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            op_i,
  input  wire logic [bce_pkg::IdxInW-1:0]      point_index_i,
  input  wire logic signed [COORD_WIDTH-1:0]   coord_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]   coord_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]   coord_z_i,
  input  wire logic [bce_pkg::TW-1:0]          t_param_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [COORD_WIDTH-1:0]        out_x_o,
  output logic signed [COORD_WIDTH-1:0]        out_y_o,
  output logic signed [COORD_WIDTH-1:0]        out_z_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bce_pkg::CfgW-1:0]        cfg_data_i
);
  import bce_pkg::*;

  localparam int IdxW = $clog2(MAX_POINTS);

  logic [CfgW-1:0] num_points_q;
  logic            busy;
  logic            in_acc;
  logic            start;
  logic            load;
  logic            emit;
  logic            out_free;
  lane_ctl_t       ctl;
  logic [IdxW-1:0] wr_pos;
  logic            out_valid_q;
  logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
  logic signed [COORD_WIDTH-1:0] front_x, front_y, front_z;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= NumPointsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_points_q <= cfg_data_i;
    end
  end

  assign in_stall_o = busy;
  assign in_acc = in_valid_i && !busy;
  assign start = in_acc && (op_i == OpEval);
  assign load = in_acc && (op_i == OpLoad);
  assign out_free = !out_valid_q || !out_stall_i;

  bce_seq #(
    .MAX_POINTS(MAX_POINTS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .t_param_i    (t_param_i),
    .num_points_i (num_points_q),
    .out_free_i   (out_free),
    .busy_o       (busy),
    .emit_o       (emit),
    .ctl_o        (ctl),
    .wr_pos_o     (wr_pos)
  );

  bce_lane #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_lane_x (
    .clk_i     (clk_i),
    .wr_en_i   (load),
    .wr_idx_i  (point_index_i),
    .wr_data_i (coord_x_i),
    .ctl_i     (ctl),
    .wr_pos_i  (wr_pos),
    .front_o   (front_x)
  );

  bce_lane #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_lane_y (
    .clk_i     (clk_i),
    .wr_en_i   (load),
    .wr_idx_i  (point_index_i),
    .wr_data_i (coord_y_i),
    .ctl_i     (ctl),
    .wr_pos_i  (wr_pos),
    .front_o   (front_y)
  );

  bce_lane #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_lane_z (
    .clk_i     (clk_i),
    .wr_en_i   (load),
    .wr_idx_i  (point_index_i),
    .wr_data_i (coord_z_i),
    .ctl_i     (ctl),
    .wr_pos_i  (wr_pos),
    .front_o   (front_z)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q <= front_x;
      out_y_q <= front_y;
      out_z_q <= front_z;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign out_z_o = out_z_q;

endmodule

`default_nettype wire

FILE: tb/bezier_curve_evaluator_top_tb.sv
`timescale 1ns / 1ps

module bezier_curve_evaluator_top_tb;
  import bce_pkg::*;

  localparam int MaxPts = 16;
  localparam int CW = 16;
  localparam int WatchLimit = 4000;
  localparam int RandomWords = 1550;
  localparam int Phases = 12;
  localparam int LongHold = 400;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    op_e op;
    logic [IdxInW-1:0] idx;
    point_t pt;
    logic [TW-1:0] t;
    logic typed;
    point_t want;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic op_i;
  logic [IdxInW-1:0] point_index_i;
  coord_t coord_x_i;
  coord_t coord_y_i;
  coord_t coord_z_i;
  logic [TW-1:0] t_param_i;
  logic out_valid_o;
  logic out_stall_i;
  coord_t out_x_o;
  coord_t out_y_o;
  coord_t out_z_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i;

  point_t ctrl_pts[MaxPts];
  logic [CfgW-1:0] num_points_reg = NumPointsReset;
  point_t curve_pts_q[$];
  int mismatches = 0;
  int evals_sent = 0;
  int gap_rate = 4;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit held_long = 1'b0;

  bezier_curve_evaluator_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .op_i(op_i),
    .point_index_i(point_index_i),
    .coord_x_i(coord_x_i),
    .coord_y_i(coord_y_i),
    .coord_z_i(coord_z_i),
    .t_param_i(t_param_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_x_o(out_x_o),
    .out_y_o(out_y_o),
    .out_z_o(out_z_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic point_t mk_point(coord_t x, coord_t y, coord_t z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic word_t load_word(logic [IdxInW-1:0] idx, point_t pt, logic [TW-1:0] t);
    word_t w;
    w = '0;
    w.op = OpLoad;
    w.idx = idx;
    w.pt = pt;
    w.t = t;
    return w;
  endfunction

  function automatic word_t eval_word(logic [TW-1:0] t, logic typed, point_t want);
    word_t w;
    w = '0;
    w.op = OpEval;
    w.idx = 4'hF;
    w.pt = mk_point(16'shFFFF, 16'sh7FFF, 16'sh8000);
    w.t = t;
    w.typed = typed;
    w.want = want;
    return w;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(7, 0))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return coord_t'(int'($urandom_range(511, 0)) - 256);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic logic [TW-1:0] rand_t();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return TOne;
      2: return TW'($urandom_range(131071, 65537));
      3: return TW'($urandom_range(3, 1));
      4: return TW'($urandom_range(65535, 65533));
      default: return TW'($urandom_range(65536, 0));
    endcase
  endfunction

  function automatic coord_t lerp_coord(longint t, longint hi, longint lo);
    longint q;
    longint r;
    q = (t * (hi - lo) + 32768) >>> 16;
    r = lo + q;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return coord_t'(r);
  endfunction

  // De Casteljau reduction over the first n stored points, one lane per coordinate.
  function automatic point_t casteljau_point(logic [TW-1:0] t_raw);
    longint wx[MaxPts];
    longint wy[MaxPts];
    longint wz[MaxPts];
    longint t;
    int n;
    point_t res;
    n = int'(num_points_reg);
    if (n < 2) n = 2;
    if (n > MaxPts) n = MaxPts;
    t = (t_raw > TOne) ? longint'(TOne) : longint'(t_raw);
    for (int j = 0; j < n; j++) begin
      wx[j] = ctrl_pts[j].x;
      wy[j] = ctrl_pts[j].y;
      wz[j] = ctrl_pts[j].z;
    end
    for (int r = 1; r < n; r++) begin
      for (int j = 0; j + r < n; j++) begin
        wx[j] = lerp_coord(t, wx[j], wx[j+1]);
        wy[j] = lerp_coord(t, wy[j], wy[j+1]);
        wz[j] = lerp_coord(t, wz[j], wz[j+1]);
      end
    end
    res.x = wx[0][CW-1:0];
    res.y = wy[0][CW-1:0];
    res.z = wz[0][CW-1:0];
    return res;
  endfunction

  task automatic log_mismatch(string what, coord_t want, coord_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: %s expected %0d got %0d", $realtime, what, want, got);
    end
  endtask

  task automatic send_word(input word_t w);
    in_valid_i <= 1'b1;
    op_i <= w.op;
    point_index_i <= w.idx;
    coord_x_i <= w.pt.x;
    coord_y_i <= w.pt.y;
    coord_z_i <= w.pt.z;
    t_param_i <= w.t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (w.op == OpLoad) begin
      ctrl_pts[w.idx] = w.pt;
    end else begin
      curve_pts_q.push_back(w.typed ? w.want : casteljau_point(w.t));
      evals_sent++;
    end
    @(negedge clk_i);
    if (!calm && gap_rate != 0 && $urandom_range(gap_rate - 1, 0) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(19, 1)) @(negedge clk_i);
    end
  endtask

  task automatic set_num_points(input logic [CfgW-1:0] v);
    in_valid_i <= 1'b0;
    while (curve_pts_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    num_points_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    word_t dir_rows[$];
    word_t w;
    point_t p0;
    point_t p10;
    point_t p0_new;
    logic [CfgW-1:0] np;
    int sent;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OpLoad;
    point_index_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    coord_z_i = '0;
    t_param_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;

    p0 = mk_point(16'sh7FFF, 16'sh8000, 16'sh1234);
    p10 = mk_point(16'sh8000, 16'sh7FFF, 16'sh0001);
    p0_new = mk_point(16'sh0001, 16'shFFFF, 16'sh0000);
    dir_rows = '{
      load_word(4'd0, p0, 17'h1FFFF),
      load_word(4'd1, mk_point(16'sh8000, 16'sh7FFF, 16'shFFFF), 17'h00000),
      load_word(4'd2, mk_point(16'sh0000, 16'shFFFF, 16'sh7FFF), 17'h10000),
      load_word(4'd3, mk_point(16'sh0100, 16'shFF00, 16'sh8000), 17'h0FFFF),
      load_word(4'd4, mk_point(16'shFFFF, 16'sh0000, 16'sh0000), 17'h00001),
      load_word(4'd5, mk_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF), 17'h1FFFF),
      load_word(4'd6, mk_point(16'sh8000, 16'sh8000, 16'sh8000), 17'h00000),
      load_word(4'd7, mk_point(16'sh1357, 16'shDB98, 16'sh0AAA), 17'h12345),
      load_word(4'd8, mk_point(16'shAAAB, 16'sh5555, 16'sh0000), 17'h00000),
      load_word(4'd9, mk_point(16'sh0080, 16'shFF80, 16'sh7FFF), 17'h08000),
      load_word(4'd10, p10, 17'h00000),
      load_word(4'd11, mk_point(16'sh4000, 16'shC000, 16'sh2000), 17'h00000),
      load_word(4'd12, mk_point(16'sh0000, 16'sh0000, 16'sh0000), 17'h1FFFF),
      load_word(4'd13, mk_point(16'sh7FFF, 16'sh8000, 16'sh7FFF), 17'h00000),
      load_word(4'd14, mk_point(16'shFFFF, 16'shFFFF, 16'shFFFF), 17'h00000),
      load_word(4'd15, mk_point(16'sh0F0F, 16'shF0F1, 16'sh7FFF), 17'h1FFFF),
      eval_word(17'h00000, 1'b1, p10),
      eval_word(TOne, 1'b1, p0),
      eval_word(17'h1FFFF, 1'b1, p0),
      eval_word(17'h10001, 1'b1, p0),
      eval_word(17'h00001, 1'b0, '0),
      eval_word(17'h08000, 1'b0, '0),
      eval_word(17'h0FFFF, 1'b0, '0),
      load_word(4'd0, p0_new, 17'h00000),
      eval_word(TOne, 1'b1, p0_new)
    };

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i]);

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: np = 5'd2;
        1: np = 5'd16;
        2: np = 5'd0;
        3: np = 5'd1;
        4: np = 5'd31;
        5: np = 5'd17;
        default: begin
          if ($urandom_range(3, 0) == 0) np = CfgW'($urandom_range(31, 0));
          else np = CfgW'($urandom_range(7, 2));
        end
      endcase
      set_num_points(np);
      calm = (p == Phases - 1);
      gap_rate = (p % 3 == 2) ? 0 : 4;
      sent = 0;
      while (sent < RandomWords / Phases) begin
        repeat ($urandom_range(3, 0)) begin
          w = load_word(IdxInW'($urandom_range(15, 0)),
                        mk_point(rand_coord(), rand_coord(), rand_coord()), rand_t());
          send_word(w);
          sent++;
        end
        w = eval_word(rand_t(), 1'b0, '0);
        w.idx = IdxInW'($urandom_range(15, 0));
        w.pt = mk_point(rand_coord(), rand_coord(), rand_coord());
        send_word(w);
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (curve_pts_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // The receiver holds off once for a long stretch so that the block backs up into its input.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_long && evals_sent >= 200) begin
        held_long = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && (evals_sent / 100) % 3 != 1 && $urandom_range(5, 0) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(19, 1)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (curve_pts_q.size() == 0) begin
        log_mismatch("result with nothing pending, out_x", '0, out_x_o);
      end else begin
        want = curve_pts_q.pop_front();
        if (out_x_o !== want.x) log_mismatch("out_x", want.x, out_x_o);
        if (out_y_o !== want.y) log_mismatch("out_y", want.y, out_y_o);
        if (out_z_o !== want.z) log_mismatch("out_z", want.z, out_z_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
